>>> design/health_checked_watchdog_top_defines.svh
// Assertion macros for the health-checked watchdog checker.
// No dependencies; expects clk and rst_n in the using scope.
`ifndef HEALTH_CHECKED_WATCHDOG_TOP_DEFINES_SVH
`define HEALTH_CHECKED_WATCHDOG_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle in reset.
`define HCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchdog check failed");

// Next-cycle implication, sampled on clk, idle in reset.
`define HCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchdog check failed");

`endif

>>> design/hcw_pkg.sv
// Shared types and constants for the health-checked watchdog.
// No dependencies.
package hcw_pkg;

    localparam int TickW    = 32;
    localparam int FailW    = 8;
    localparam int ActionW  = 3;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 32;

    localparam logic [ActionW-1:0] ACT_TICK    = 3'd0;
    localparam logic [ActionW-1:0] ACT_START   = 3'd1;
    localparam logic [ActionW-1:0] ACT_FEED    = 3'd2;
    localparam logic [ActionW-1:0] ACT_CHECK   = 3'd3;
    localparam logic [ActionW-1:0] ACT_RECOVER = 3'd4;

    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_LIMIT   = 1'd1;

    localparam logic [TickW-1:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [FailW-1:0] LIMIT_RESET   = 8'd3;
    localparam logic [FailW-1:0] FAIL_MAX      = 8'hFF;

    typedef struct packed {
        logic [ActionW-1:0] action;
        logic               health_ok;
        logic               low_memory;
    } item_t;

    typedef struct packed {
        logic             armed;
        logic [TickW-1:0] time_remaining;
        logic [FailW-1:0] failure_count;
        logic             last_check_passed;
        logic             fail_safe;
        logic             reset_request;
        logic             action_ok;
    } result_t;

    typedef struct packed {
        logic valid;
        logic stall;
    } hshk_t;

endpackage

>>> design/hcw_in_stage.sv
// Input request register for the health-checked watchdog.
// Depends on hcw_pkg.
module hcw_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  hcw_pkg::item_t in_item,
    input  logic          advance,
    output logic          held_valid,
    output hcw_pkg::item_t held_item
);

    logic           valid_reg;
    logic           valid_next;
    hcw_pkg::item_t item_reg;
    logic           take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> design/hcw_core.sv
// Watchdog state, configuration registers and per-request update logic.
// Depends on hcw_pkg.
module hcw_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hcw_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hcw_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         fire,
    input  hcw_pkg::item_t               item,
    output hcw_pkg::result_t             result
);

    logic [hcw_pkg::TickW-1:0] timeout_reg;
    logic [hcw_pkg::FailW-1:0] limit_reg;
    logic                      armed_reg;
    logic                      armed_next;
    logic [hcw_pkg::TickW-1:0] elapsed_reg;
    logic [hcw_pkg::TickW-1:0] elapsed_next;
    logic [hcw_pkg::FailW-1:0] failures_reg;
    logic [hcw_pkg::FailW-1:0] failures_next;
    logic                      fail_safe_reg;
    logic                      fail_safe_next;
    logic [hcw_pkg::FailW-1:0] failures_inc;
    logic                      rst_req;
    logic                      ok;
    logic                      expired;

    assign failures_inc = (failures_reg == hcw_pkg::FAIL_MAX) ? failures_reg
                                                             : failures_reg + 8'd1;

    always_comb
    begin
        armed_next     = armed_reg;
        elapsed_next   = elapsed_reg;
        failures_next  = failures_reg;
        fail_safe_next = fail_safe_reg;
        ok             = 1'b1;
        unique case (item.action)
            hcw_pkg::ACT_TICK:
            begin
                if (armed_reg && (elapsed_reg < timeout_reg))
                begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end
            hcw_pkg::ACT_START:
            begin
                armed_next     = 1'b1;
                elapsed_next   = '0;
                failures_next  = '0;
                fail_safe_next = 1'b0;
            end
            hcw_pkg::ACT_FEED:
            begin
                if (armed_reg)
                begin
                    elapsed_next = '0;
                end
                failures_next = '0;
            end
            hcw_pkg::ACT_CHECK:
            begin
                if (item.health_ok && !item.low_memory)
                begin
                    if (armed_reg)
                    begin
                        elapsed_next = '0;
                    end
                    failures_next = '0;
                end
                else
                begin
                    ok            = 1'b0;
                    failures_next = failures_inc;
                    if ((failures_inc >= limit_reg) && !fail_safe_reg)
                    begin
                        fail_safe_next = 1'b1;
                        if (armed_reg)
                        begin
                            elapsed_next = '0;
                        end
                        failures_next = '0;
                    end
                end
            end
            hcw_pkg::ACT_RECOVER:
            begin
                if (fail_safe_reg)
                begin
                    if (!item.low_memory && (failures_reg == '0))
                    begin
                        fail_safe_next = 1'b0;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign expired = !armed_next || (elapsed_next >= timeout_reg);
    assign rst_req = (item.action == hcw_pkg::ACT_TICK) && armed_reg && expired;

    assign result.armed             = armed_next;
    assign result.time_remaining    = expired ? '0 : (timeout_reg - elapsed_next);
    assign result.failure_count     = failures_next;
    assign result.last_check_passed = (failures_next == '0);
    assign result.fail_safe         = fail_safe_next;
    assign result.reset_request     = rst_req;
    assign result.action_ok         = ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= hcw_pkg::TIMEOUT_RESET;
            limit_reg   <= hcw_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hcw_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                hcw_pkg::CFG_LIMIT:   limit_reg   <= cfg_data[hcw_pkg::FailW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            elapsed_reg   <= '0;
            failures_reg  <= '0;
            fail_safe_reg <= 1'b0;
        end
        else if (fire)
        begin
            armed_reg     <= armed_next;
            elapsed_reg   <= elapsed_next;
            failures_reg  <= failures_next;
            fail_safe_reg <= fail_safe_next;
        end
    end

endmodule

>>> design/hcw_out_stage.sv
// Result register for the health-checked watchdog, holds under stall.
// Depends on hcw_pkg.
module hcw_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             held_valid,
    input  hcw_pkg::result_t next_result,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_stall,
    output hcw_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    hcw_pkg::result_t result_reg;

    assign advance = held_valid && (!valid_reg || !out_stall);

    always_comb
    begin
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= next_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

>>> design/health_checked_watchdog_top.sv
// Top level of the health-checked watchdog: input register, core, result register.
// Depends on hcw_pkg, hcw_in_stage, hcw_core, hcw_out_stage.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | action, health_ok, low_memory
//  out      | out_valid / out_stall| armed, time_remaining, failure_count,
//           |                      | last_check_passed, fail_safe, reset_request,
//           |                      | action_ok
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; out_valid rises once the result register loads.
// State is updated as a request moves from the input register to the result register.
// A stalled result holds the input register once it is full; in_stall then rises.
// Reset is asynchronous, active low; no clearing pass, ready as soon as reset is released.
module health_checked_watchdog_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hcw_pkg::ActionW-1:0]   action,
    input  logic                          health_ok,
    input  logic                          low_memory,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          armed,
    output logic [hcw_pkg::TickW-1:0]     time_remaining,
    output logic [hcw_pkg::FailW-1:0]     failure_count,
    output logic                          last_check_passed,
    output logic                          fail_safe,
    output logic                          reset_request,
    output logic                          action_ok,
    input  logic                          cfg_we,
    input  logic [hcw_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [hcw_pkg::CfgDataW-1:0]  cfg_data
);

    hcw_pkg::item_t   in_item;
    hcw_pkg::item_t   held_item;
    hcw_pkg::result_t next_result;
    hcw_pkg::result_t out_result;
    logic             held_valid;
    logic             advance;

    assign in_item.action     = action;
    assign in_item.health_ok  = health_ok;
    assign in_item.low_memory = low_memory;

    hcw_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    hcw_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (held_item),
        .result    (next_result)
    );

    hcw_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .held_valid  (held_valid),
        .next_result (next_result),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_result  (out_result)
    );

    assign armed             = out_result.armed;
    assign time_remaining    = out_result.time_remaining;
    assign failure_count     = out_result.failure_count;
    assign last_check_passed = out_result.last_check_passed;
    assign fail_safe         = out_result.fail_safe;
    assign reset_request     = out_result.reset_request;
    assign action_ok         = out_result.action_ok;

endmodule

>>> design/hcw_checker.sv
// Port-level checker for the health-checked watchdog, bound to the top level.
// Depends on hcw_pkg and health_checked_watchdog_top_defines.svh.
`include "health_checked_watchdog_top_defines.svh"

module hcw_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic                      armed,
    input  logic [hcw_pkg::TickW-1:0] time_remaining,
    input  logic [hcw_pkg::FailW-1:0] failure_count,
    input  logic                      last_check_passed,
    input  logic                      reset_request
);

    `HCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(time_remaining) && $stable(failure_count))
    `HCW_ASSERT_NOW(a_pass_flag, out_valid, last_check_passed == (failure_count == '0))
    `HCW_ASSERT_NOW(a_disarmed, out_valid && !armed, (time_remaining == '0) && !reset_request)
    `HCW_ASSERT_NOW(a_rst_req, out_valid && reset_request, armed && (time_remaining == '0))

endmodule

bind health_checked_watchdog_top hcw_checker u_hcw_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .armed             (armed),
    .time_remaining    (time_remaining),
    .failure_count     (failure_count),
    .last_check_passed (last_check_passed),
    .reset_request     (reset_request)
);

>>> tb/sv/hcw_status_checker.sv
`timescale 1ns / 1ps
// Status checker for the health-checked watchdog: tracks the watchdog state from accepted
// requests and config writes, and compares every accepted status against it. Uses hcw_pkg.
module hcw_status_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [hcw_pkg::ActionW-1:0]   action,
    input  logic                          health_ok,
    input  logic                          low_memory,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          armed,
    input  logic [hcw_pkg::TickW-1:0]     time_remaining,
    input  logic [hcw_pkg::FailW-1:0]     failure_count,
    input  logic                          last_check_passed,
    input  logic                          fail_safe,
    input  logic                          reset_request,
    input  logic                          action_ok,
    input  logic                          cfg_we,
    input  logic [hcw_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [hcw_pkg::CfgDataW-1:0]  cfg_data,
    output int                            mismatch_count,
    output int                            pending
);

    import hcw_pkg::*;

    logic [TickW-1:0] timeout_r;
    logic [FailW-1:0] limit_r;
    logic             armed_r;
    logic [TickW-1:0] elapsed_r;
    logic [FailW-1:0] failures_r;
    logic             fail_safe_r;

    result_t status_q[$];

    function automatic logic [TickW-1:0] ticks_left();
        if (!armed_r || elapsed_r >= timeout_r)
            return '0;
        return timeout_r - elapsed_r;
    endfunction

    function automatic void feed_dog();
        if (armed_r)
            elapsed_r = '0;
        failures_r = '0;
    endfunction

    function automatic result_t predict_status(logic [ActionW-1:0] act, logic hok, logic lowm);
        result_t st;
        st.reset_request = 1'b0;
        st.action_ok     = 1'b1;
        case (act)
            ACT_TICK:
            begin
                if (armed_r)
                begin
                    if (elapsed_r < timeout_r)
                        elapsed_r = elapsed_r + 1'b1;
                    st.reset_request = (ticks_left() == '0);
                end
            end
            ACT_START:
            begin
                armed_r     = 1'b1;
                elapsed_r   = '0;
                failures_r  = '0;
                fail_safe_r = 1'b0;
            end
            ACT_FEED:
                feed_dog();
            ACT_CHECK:
            begin
                if (hok && !lowm)
                    feed_dog();
                else
                begin
                    st.action_ok = 1'b0;
                    if (failures_r != FAIL_MAX)
                        failures_r = failures_r + 1'b1;
                    if (failures_r >= limit_r && !fail_safe_r)
                    begin
                        fail_safe_r = 1'b1;
                        feed_dog();
                    end
                end
            end
            ACT_RECOVER:
            begin
                if (fail_safe_r)
                begin
                    if (!lowm && failures_r == '0)
                        fail_safe_r = 1'b0;
                    else
                        st.action_ok = 1'b0;
                end
            end
            default: ;
        endcase
        st.armed             = armed_r;
        st.time_remaining    = ticks_left();
        st.failure_count     = failures_r;
        st.last_check_passed = (failures_r == '0);
        st.fail_safe         = fail_safe_r;
        return st;
    endfunction

    task automatic check_field(string name, logic [TickW-1:0] exp, logic [TickW-1:0] got);
        if (exp !== got)
        begin
            $display("%0t ns: %s expected %0h, actual %0h", $time, name, exp, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp;
        if (!rst_n)
        begin
            timeout_r      = TIMEOUT_RESET;
            limit_r        = LIMIT_RESET;
            armed_r        = 1'b0;
            elapsed_r      = '0;
            failures_r     = '0;
            fail_safe_r    = 1'b0;
            mismatch_count = 0;
            status_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t ns: status expected none, actual time_remaining %0h",
                             $time, time_remaining);
                    mismatch_count++;
                end
                else
                begin
                    exp = status_q.pop_front();
                    check_field("armed", exp.armed, armed);
                    check_field("time_remaining", exp.time_remaining, time_remaining);
                    check_field("failure_count", exp.failure_count, failure_count);
                    check_field("last_check_passed", exp.last_check_passed, last_check_passed);
                    check_field("fail_safe", exp.fail_safe, fail_safe);
                    check_field("reset_request", exp.reset_request, reset_request);
                    check_field("action_ok", exp.action_ok, action_ok);
                end
            end
            if (in_valid && !in_stall)
                status_q.push_back(predict_status(action, health_ok, low_memory));
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_r = cfg_data[TickW-1:0];
                else if (cfg_index == CFG_LIMIT)
                    limit_r = cfg_data[FailW-1:0];
            end
        end
        pending = status_q.size();
    end

endmodule

>>> tb/sv/health_checked_watchdog_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the health-checked watchdog: clock, reset, request and config stimulus,
// result stalls and the verdict. Depends on hcw_pkg, hcw_status_checker and the block.
module health_checked_watchdog_top_tb;

    import hcw_pkg::*;

    localparam logic [ActionW-1:0] ACT_SPARE_MAX = 3'd7;
    localparam int QUIET_LIMIT = 4000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ActionW-1:0]   action;
    logic                 health_ok;
    logic                 low_memory;
    logic                 out_valid;
    logic                 out_stall;
    logic                 armed;
    logic [TickW-1:0]     time_remaining;
    logic [FailW-1:0]     failure_count;
    logic                 last_check_passed;
    logic                 fail_safe;
    logic                 reset_request;
    logic                 action_ok;
    logic                 cfg_we;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CfgDataW-1:0]  cfg_data;

    int  mismatches;
    int  pending;
    int  quiet_cycles;
    int  stall_left;
    logic gaps_on;
    logic stalls_on;

    health_checked_watchdog_top dut (.*);

    hcw_status_checker checker_i (.*, .mismatch_count(mismatches), .pending(pending));

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_req(logic [ActionW-1:0] act, logic hok, logic lowm);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        health_ok  <= hok;
        low_memory <= lowm;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic [TickW-1:0] tmo, logic [FailW-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= {{(CfgDataW-FailW){1'b0}}, lim};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Weighted mix: mostly ticks and health checks, with occasional restarts.
    task automatic rand_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_req(ACT_TICK, $urandom_range(0, 1), $urandom_range(0, 1));
        else if (r < 45)
            send_req(ACT_START, $urandom_range(0, 1), $urandom_range(0, 1));
        else if (r < 55)
            send_req(ACT_FEED, $urandom_range(0, 1), $urandom_range(0, 1));
        else if (r < 85)
            send_req(ACT_CHECK, $urandom_range(0, 2) != 0, $urandom_range(0, 3) == 0);
        else if (r < 95)
            send_req(ACT_RECOVER, $urandom_range(0, 1), $urandom_range(0, 2) == 0);
        else
            send_req($urandom_range(ACT_RECOVER + 1, ACT_SPARE_MAX),
                     $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic pick_config();
        logic [TickW-1:0] tmo;
        logic [FailW-1:0] lim;
        case ($urandom_range(0, 5))
            0:       tmo = '0;
            1:       tmo = $urandom_range(1, 4);
            2, 3:    tmo = $urandom_range(5, 40);
            4:       tmo = '1;
            default: tmo = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0:       lim = 8'd1;
            1:       lim = FAIL_MAX;
            2:       lim = $urandom_range(1, FAIL_MAX);
            default: lim = $urandom_range(2, 6);
        endcase
        set_config(tmo, lim);
    endtask

    initial
    begin
        int ph;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_TICK;
        health_ok  = 1'b0;
        low_memory = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_TIMEOUT;
        cfg_data   = '0;
        gaps_on    = 1'b1;
        stalls_on  = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unarmed corners, unused actions, then the fail-safe entry and exit path
        send_req(ACT_TICK, 1'b1, 1'b1);
        send_req(ACT_FEED, 1'b0, 1'b0);
        send_req(ACT_RECOVER, 1'b0, 1'b1);
        send_req(ACT_CHECK, 1'b0, 1'b0);
        send_req(ACT_RECOVER + 1, 1'b1, 1'b0);
        send_req(ACT_SPARE_MAX, 1'b0, 1'b1);
        send_req(ACT_START, 1'b0, 1'b0);
        send_req(ACT_TICK, 1'b0, 1'b0);
        send_req(ACT_CHECK, 1'b1, 1'b0);
        send_req(ACT_CHECK, 1'b1, 1'b1);
        send_req(ACT_CHECK, 1'b0, 1'b0);
        send_req(ACT_CHECK, 1'b0, 1'b1);
        send_req(ACT_RECOVER, 1'b1, 1'b1);
        send_req(ACT_CHECK, 1'b0, 1'b0);
        send_req(ACT_RECOVER, 1'b1, 1'b0);
        send_req(ACT_FEED, 1'b1, 1'b1);
        send_req(ACT_RECOVER, 1'b0, 1'b0);

        // zero timeout and zero failure limit
        drain();
        set_config('0, '0);
        send_req(ACT_TICK, 1'b0, 1'b0);
        send_req(ACT_CHECK, 1'b0, 1'b0);
        send_req(ACT_START, 1'b1, 1'b0);

        // saturate elapsed time, then lower the timeout beneath it
        drain();
        set_config(32'd3, LIMIT_RESET);
        repeat (5) send_req(ACT_TICK, 1'b0, 1'b0);
        drain();
        set_config(32'd1, 8'd1);
        send_req(ACT_TICK, 1'b1, 1'b1);
        send_req(ACT_FEED, 1'b0, 1'b0);
        send_req(ACT_TICK, 1'b0, 1'b0);

        for (ph = 0; ph < 7; ph++)
        begin
            drain();
            pick_config();
            gaps_on   <= $urandom_range(0, 2) != 0;
            stalls_on <= $urandom_range(0, 2) != 0;
            repeat (170) rand_req();
            if (ph == 2)
            begin
                // long run of failed checks drives the count to saturation in fail-safe
                drain();
                set_config('1, LIMIT_RESET);
                send_req(ACT_START, 1'b0, 1'b0);
                repeat (300) send_req(ACT_CHECK, $urandom_range(0, 1), $urandom_range(0, 1) != 0
                                      ? 1'b1 : 1'b1);
                send_req(ACT_RECOVER, 1'b0, 1'b0);
                send_req(ACT_TICK, 1'b0, 1'b0);
            end
        end

        drain();
        pick_config();
        gaps_on   <= 1'b0;
        stalls_on <= 1'b0;
        repeat (100) rand_req();

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
